>>> hw/rtl/utf8nv_pkg.sv
// Package for the UTF-8 name validator: beat structs, reason codes,
// sequence classes and byte constants. No dependencies.
package utf8nv_pkg;

    // Result reason codes, in priority order of the final verdict
    typedef enum logic [2:0] {
        REASON_OK         = 3'd0,
        REASON_TOO_LONG   = 3'd1,
        REASON_EDGE_SPACE = 3'd2,
        REASON_BAD_ENC    = 3'd3,
        REASON_FORBIDDEN  = 3'd4,
        REASON_EDGE_WS    = 3'd5
    } reason_t;

    // Multi-byte form expected after a lead byte
    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_class_t;

    localparam logic [10:0] BYTE_CAP   = 11'd1024;
    localparam logic [9:0]  MAX_RESET  = 10'd255;
    localparam logic [7:0]  SPACE_BYTE = 8'h20;

    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;
    localparam logic [20:0] SCALAR_MAX = 21'h10ffff;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;

    // One input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic        name_ok;
        reason_t     fail_reason;
        logic [10:0] byte_total;
    } out_beat_t;

    // Character class flags from the scalar classifier
    typedef struct packed {
        logic is_space;
        logic is_forbidden;
    } char_flags_t;

endpackage

>>> hw/rtl/utf8nv_char_class.sv
// Scalar classifier: Unicode whitespace and forbidden-character ranges.
// Depends on utf8nv_pkg.
module utf8nv_char_class (
    input  logic [20:0]               scalar,
    output utf8nv_pkg::char_flags_t   flags
);
    import utf8nv_pkg::*;

    // Whitespace scalars
    always_comb begin
        flags.is_space =
            (scalar >= 21'h09   && scalar <= 21'h0d)   ||
            (scalar >= 21'h1c   && scalar <= 21'h20)   ||
            scalar == 21'h85    || scalar == 21'ha0    ||
            scalar == 21'h1680  ||
            (scalar >= 21'h2000 && scalar <= 21'h200a) ||
            scalar == 21'h2028  || scalar == 21'h2029  ||
            scalar == 21'h202f  || scalar == 21'h205f  ||
            scalar == 21'h3000;
    end

    // Controls, separators, combining marks, format characters, BOM
    always_comb begin
        flags.is_forbidden =
            scalar <= 21'h1f    || scalar == 21'h7f    ||
            scalar == 21'h2028  || scalar == 21'h2029  ||
            (scalar >= 21'h0300 && scalar <= 21'h036f) ||
            (scalar >= 21'h1ab0 && scalar <= 21'h1aff) ||
            (scalar >= 21'h1dc0 && scalar <= 21'h1dff) ||
            (scalar >= 21'h20d0 && scalar <= 21'h20ff) ||
            (scalar >= 21'hfe20 && scalar <= 21'hfe2f) ||
            (scalar >= 21'h200b && scalar <= 21'h200f) ||
            (scalar >= 21'h202a && scalar <= 21'h202e) ||
            (scalar >= 21'h2060 && scalar <= 21'h206f) ||
            scalar == 21'hfeff;
    end

endmodule

>>> hw/rtl/utf8nv_decoder.sv
// Per-name decode state and the single-byte update step with verdict.
// Depends on utf8nv_pkg and utf8nv_char_class.
module utf8nv_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  utf8nv_pkg::in_beat_t  in_beat,
    input  logic [9:0]            max_name_bytes,
    output utf8nv_pkg::out_beat_t verdict
);
    import utf8nv_pkg::*;

    logic [10:0] bytes_seen_reg,  bytes_seen_next;
    logic [1:0]  cont_left_reg,   cont_left_next;
    logic [20:0] partial_reg,     partial_next;
    seq_class_t  seq_class_reg,   seq_class_next;
    logic        first_done_reg,  first_done_next;
    logic        first_ws_reg,    first_ws_next;
    logic        last_ws_reg,     last_ws_next;
    logic        first_sp_reg,    first_sp_next;
    reason_t     sticky_reg,      sticky_next;

    logic [7:0]  b;
    logic [20:0] partial_shift;
    logic [20:0] scalar_sel;
    logic [20:0] minimum;
    logic        take;
    char_flags_t flags;
    reason_t     reason;

    assign b             = in_beat.text_byte;
    assign partial_shift = {partial_reg[14:0], b[5:0]};
    assign scalar_sel    = (cont_left_reg == 2'd0) ? {13'd0, b} : partial_shift;

    utf8nv_char_class u_class (
        .scalar (scalar_sel),
        .flags  (flags)
    );

    // Smallest scalar allowed for the current form
    always_comb begin
        case (seq_class_reg)
            SEQ_TWO:   minimum = MIN_TWO;
            SEQ_THREE: minimum = MIN_THREE;
            default:   minimum = MIN_FOUR;
        endcase
    end

    // Byte step: count, decode, classify
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        cont_left_next  = cont_left_reg;
        partial_next    = partial_reg;
        seq_class_next  = seq_class_reg;
        first_done_next = first_done_reg;
        first_ws_next   = first_ws_reg;
        last_ws_next    = last_ws_reg;
        first_sp_next   = first_sp_reg;
        sticky_next     = sticky_reg;
        take            = 1'b0;

        if (bytes_seen_reg == 11'd0) begin
            first_sp_next = (b == SPACE_BYTE);
        end
        if (bytes_seen_reg < BYTE_CAP) begin
            bytes_seen_next = bytes_seen_reg + 11'd1;
        end

        if (sticky_reg == REASON_OK) begin
            if (cont_left_reg == 2'd0) begin
                if (!b[7]) begin
                    take = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    partial_next   = {16'd0, b[4:0]};
                    cont_left_next = 2'd1;
                    seq_class_next = SEQ_TWO;
                end else if (b[7:4] == 4'b1110) begin
                    partial_next   = {17'd0, b[3:0]};
                    cont_left_next = 2'd2;
                    seq_class_next = SEQ_THREE;
                end else if (b[7:3] == 5'b11110) begin
                    partial_next   = {18'd0, b[2:0]};
                    cont_left_next = 2'd3;
                    seq_class_next = SEQ_FOUR;
                end else begin
                    sticky_next = REASON_BAD_ENC;
                end
            end else if (b[7:6] != 2'b10) begin
                sticky_next = REASON_BAD_ENC;
            end else begin
                partial_next   = partial_shift;
                cont_left_next = cont_left_reg - 2'd1;
                if (cont_left_reg == 2'd1) begin
                    // sequence complete: overlong, range, surrogate
                    if (partial_shift < minimum || partial_shift > SCALAR_MAX ||
                        (partial_shift >= SURR_LO && partial_shift <= SURR_HI)) begin
                        sticky_next = REASON_BAD_ENC;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
        end

        // Whole scalar decoded
        if (take) begin
            if (flags.is_forbidden) begin
                sticky_next = REASON_FORBIDDEN;
            end else begin
                if (!first_done_reg) begin
                    first_done_next = 1'b1;
                    first_ws_next   = flags.is_space;
                end
                last_ws_next = flags.is_space;
            end
        end
    end

    // Verdict for a final byte
    always_comb begin
        if (bytes_seen_next > {1'b0, max_name_bytes}) begin
            reason = REASON_TOO_LONG;
        end else if (first_sp_next || b == SPACE_BYTE) begin
            reason = REASON_EDGE_SPACE;
        end else if (sticky_next != REASON_OK) begin
            reason = sticky_next;
        end else if (cont_left_next != 2'd0) begin
            reason = REASON_BAD_ENC;
        end else if (first_ws_next || last_ws_next) begin
            reason = REASON_EDGE_WS;
        end else begin
            reason = REASON_OK;
        end
        verdict.name_ok     = (reason == REASON_OK);
        verdict.fail_reason = reason;
        verdict.byte_total  = bytes_seen_next;
    end

    // State registers, cleared after each final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && in_beat.is_last)) begin
            bytes_seen_reg <= 11'd0;
            cont_left_reg  <= 2'd0;
            partial_reg    <= 21'd0;
            seq_class_reg  <= SEQ_NONE;
            first_done_reg <= 1'b0;
            first_ws_reg   <= 1'b0;
            last_ws_reg    <= 1'b0;
            first_sp_reg   <= 1'b0;
            sticky_reg     <= REASON_OK;
        end else if (step_en) begin
            bytes_seen_reg <= bytes_seen_next;
            cont_left_reg  <= cont_left_next;
            partial_reg    <= partial_next;
            seq_class_reg  <= seq_class_next;
            first_done_reg <= first_done_next;
            first_ws_reg   <= first_ws_next;
            last_ws_reg    <= last_ws_next;
            first_sp_reg   <= first_sp_next;
            sticky_reg     <= sticky_next;
        end
    end

endmodule

>>> hw/rtl/utf8_name_validator.sv
// Top level of the UTF-8 name validator: input register, decoder, result
// register and the length-limit register. Depends on utf8nv_pkg, utf8nv_decoder.
//
// Usage:
//   s_valid/s_ready/s_data carry one name byte per beat; is_last marks the
//   final byte. m_valid/m_ready/m_data carry one verdict per name (name_ok,
//   fail_reason, byte_total), issued for the final byte only.
//   cfg_valid/cfg_ready/cfg_data write max_name_bytes (reset 255); cfg_ready
//   is always high. Write it only while no name is in flight.
// Timing:
//   A byte waits in the input register, is decoded in a single pass against
//   the per-name state, and the verdict is registered onto m_valid. One byte
//   per cycle sustained, unless a final byte waits on a busy result register.
// Reset:
//   aresetn low clears the pipeline and the per-name state, and sets the limit
//   back to 255.
// Stall:
//   Non-final bytes keep flowing while a verdict waits on m_ready. A final byte
//   waits in the input register until the result register frees, and s_ready
//   drops behind it.
module utf8_name_validator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8nv_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8nv_pkg::out_beat_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [9:0]            cfg_data
);
    import utf8nv_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic [9:0] max_bytes_reg;
    logic      advance;
    out_beat_t verdict;

    // A final byte needs a free result register; others always advance
    assign advance   = in_valid_reg &&
                       (!in_data_reg.is_last || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_bytes_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    utf8nv_decoder u_decoder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .in_beat        (in_data_reg),
        .max_name_bytes (max_bytes_reg),
        .verdict        (verdict)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_data_reg.is_last) begin
            out_data_reg <= verdict;
        end
    end

    // Checks
    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.name_ok == (m_data.fail_reason == REASON_OK)))
        else $error("name_ok disagrees with fail_reason");

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_total != 11'd0 && m_data.byte_total <= BYTE_CAP))
        else $error("byte_total out of range");

    a_final_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_data_reg.is_last && m_valid && !m_ready) |-> !s_ready)
        else $error("final byte advanced into a busy result register");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    a_verdict_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.is_last) |=> m_valid)
        else $error("final byte produced no verdict");

endmodule
